### sv/sliding_window_mean_with_missing_top_macros.svh
// Assertion macros shared by the sliding window mean RTL.
`ifndef SLIDING_WINDOW_MEAN_WITH_MISSING_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEAN_WITH_MISSING_TOP_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define SWMM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sliding window mean: assertion failed");

// The antecedent implies the consequent in the next cycle.
`define SWMM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sliding window mean: assertion failed");

`endif

### sv/swmm_pkg.sv
// Package with the widths and register indexes of the sliding window mean block.
package swmm_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int NUM_COLUMNS_W = 4;
  localparam int WINDOW_SIZE_W = 11;
  localparam int STEP_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP = 2'd2;

  localparam logic [NUM_COLUMNS_W-1:0] NUM_COLUMNS_RESET = 4'd1;
  localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RESET = 11'd1000;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd1;

endpackage

### sv/swmm_ram.sv
// Single-port synchronous RAM with a registered read.
module swmm_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sliding_window_mean_with_missing_top.sv
// Top level of the sliding window mean with missing samples.
//
// Samples arrive one item at a time on the input channel in row order,
// column 0 first, each with a present flag. Once a full window of rows has
// been seen, every step-th row produces one output item per column: the
// truncated mean of the present samples in that column's window, or a
// cleared mean_valid when the window holds none. last_in_row marks the
// row's last column.
// Each item reads the sample ring, writes it back and updates the column
// sum; a result then loads the divider, runs the radix-2 divider, rounds
// the sign and loads the output register. A result for a window without
// present samples skips the divider. in_stall_o is high while an item is
// in work.
// The output register holds a result until it is taken; a stalled output
// holds the next result in the divider and delays the next input item.
// Reset loads the register defaults and clears sums, counts and positions.
// Each of the three register writes clears them too; write only while idle.
// The sample ring needs no clearing pass: its data is used only once written.
`include "sliding_window_mean_with_missing_top_macros.svh"

module sliding_window_mean_with_missing_top #(
  parameter int MAX_COLUMNS = 8,
  parameter int MAX_WINDOW = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swmm_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [swmm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [swmm_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                present_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [swmm_pkg::SAMPLE_BITS-1:0] mean_o,
  output logic                                mean_valid_o,
  output logic                                last_in_row_o
);

  import swmm_pkg::*;

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int COLN_W = $clog2(MAX_COLUMNS + 1);
  localparam int POS_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int ADDR_W = COL_W + POS_W;
  localparam int RAM_W = SAMPLE_BITS + 1;
  localparam int ITER_W = $clog2(SAMPLE_BITS);
  localparam int DELTA_W = SAMPLE_BITS + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVICT = 3'd1;
  localparam logic [2:0] S_ACC = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state_q;

  logic [NUM_COLUMNS_W-1:0] num_cols_q;
  logic [WINDOW_SIZE_W-1:0] win_q;
  logic [STEP_W-1:0]        step_q;

  logic [COL_W-1:0]  col_q;
  logic [POS_W-1:0]  pos_q;
  logic [CNT_W-1:0]  rows_q;
  logic [STEP_W-1:0] step_cnt_q;

  logic signed [SUM_W-1:0] sum_q [MAX_COLUMNS];
  logic [CNT_W-1:0]        cnt_q [MAX_COLUMNS];

  logic [ADDR_W-1:0]             addr_q;
  logic [COL_W-1:0]              wcol_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          pres_q;
  logic                          evict_q;
  logic                          emit_q;
  logic                          last_q;
  logic signed [DELTA_W-1:0]     delta_q;
  logic                          oldp_q;

  logic [CNT_W-1:0]       rem_q;
  logic [CNT_W-1:0]       div_q;
  logic [SAMPLE_BITS-1:0] quo_q;
  logic [ITER_W-1:0]      iter_q;
  logic                   neg_q;
  logic                   res_valid_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] mean_q;
  logic                          mean_valid_q;
  logic                          last_in_row_q;

  logic [COLN_W-1:0] cols_eff;
  logic [CNT_W-1:0]  ws_eff;
  logic [STEP_W-1:0] step_eff;
  logic              in_accept;
  logic              clear_path;
  logic              full;
  logic              evict;
  logic              last;
  logic              emit;
  logic [STEP_W-1:0] step_inc;
  logic [POS_W-1:0]  pos_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;

  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic signed [SUM_W-1:0]       sum_sel;
  logic [SUM_W-1:0]              mag;
  logic [CNT_W:0]                trial;
  logic                          ge;
  logic signed [SAMPLE_BITS-1:0] mean_d;
  logic                          out_free;

  always_comb begin
    if (num_cols_q == '0) begin
      cols_eff = COLN_W'(1);
    end else if (32'(num_cols_q) > MAX_COLUMNS) begin
      cols_eff = COLN_W'(MAX_COLUMNS);
    end else begin
      cols_eff = COLN_W'(num_cols_q);
    end
    if (win_q == '0) begin
      ws_eff = CNT_W'(1);
    end else if (32'(win_q) > MAX_WINDOW) begin
      ws_eff = CNT_W'(MAX_WINDOW);
    end else begin
      ws_eff = CNT_W'(win_q);
    end
    step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  assign clear_path = cfg_we_i &&
                      (cfg_index_i == CFG_NUM_COLUMNS || cfg_index_i == CFG_WINDOW_SIZE ||
                       cfg_index_i == CFG_STEP);

  always_comb begin
    full = ((CNT_W + 1)'(rows_q) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(ws_eff);
    evict = rows_q >= ws_eff;
    last = ((COLN_W + 1)'(col_q) + (COLN_W + 1)'(1)) >= (COLN_W + 1)'(cols_eff);
    step_inc = ((col_q == '0) && full) ? step_cnt_q + STEP_W'(1) : step_cnt_q;
    emit = full && (step_inc == step_eff);
    if (((CNT_W + 1)'(pos_q) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(ws_eff)) begin
      pos_next = '0;
    end else begin
      pos_next = pos_q + POS_W'(1);
    end
  end

  assign ram_we = (state_q == S_EVICT);
  assign ram_addr = (state_q == S_EVICT) ? addr_q : {col_q, pos_q};
  assign ram_wdata = {pres_q, sample_q};

  swmm_ram #(
    .WIDTH(RAM_W),
    .DEPTH(2 ** ADDR_W)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    old_sample = evict_q ? $signed(ram_rdata[SAMPLE_BITS-1:0]) : '0;
    sum_sel = sum_q[wcol_q];
    mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    trial = {rem_q, quo_q[SAMPLE_BITS-1]};
    ge = trial >= {1'b0, div_q};
    mean_d = neg_q ? -$signed(quo_q) : $signed(quo_q);
    out_free = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      num_cols_q <= NUM_COLUMNS_RESET;
      win_q <= WINDOW_SIZE_RESET;
      step_q <= STEP_RESET;
      col_q <= '0;
      pos_q <= '0;
      rows_q <= '0;
      step_cnt_q <= '0;
      evict_q <= 1'b0;
      emit_q <= 1'b0;
      last_q <= 1'b0;
      iter_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_NUM_COLUMNS: num_cols_q <= cfg_data_i[NUM_COLUMNS_W-1:0];
          CFG_WINDOW_SIZE: win_q <= cfg_data_i[WINDOW_SIZE_W-1:0];
          CFG_STEP: step_q <= cfg_data_i[STEP_W-1:0];
          default: begin
          end
        endcase
      end

      if (!clear_path && state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (clear_path) begin
        col_q <= '0;
        pos_q <= '0;
        rows_q <= '0;
        step_cnt_q <= '0;
        for (int i = 0; i < MAX_COLUMNS; i++) begin
          sum_q[i] <= '0;
          cnt_q[i] <= '0;
        end
      end else begin
        case (state_q)
          S_IDLE: begin
            if (in_accept) begin
              evict_q <= evict;
              emit_q <= emit;
              last_q <= last;
              step_cnt_q <= (last && emit) ? '0 : step_inc;
              if (last) begin
                col_q <= '0;
                pos_q <= pos_next;
                if (rows_q < ws_eff) begin
                  rows_q <= rows_q + CNT_W'(1);
                end
              end else begin
                col_q <= col_q + COL_W'(1);
              end
              state_q <= S_EVICT;
            end
          end
          S_EVICT: begin
            state_q <= S_ACC;
          end
          S_ACC: begin
            sum_q[wcol_q] <= sum_q[wcol_q] + SUM_W'(delta_q);
            cnt_q[wcol_q] <= cnt_q[wcol_q] + CNT_W'(pres_q) - CNT_W'(oldp_q);
            state_q <= emit_q ? S_PREP : S_IDLE;
          end
          S_PREP: begin
            iter_q <= '0;
            state_q <= (cnt_q[wcol_q] == '0) ? S_OUT : S_DIV;
          end
          S_DIV: begin
            iter_q <= iter_q + ITER_W'(1);
            if (iter_q == ITER_W'(SAMPLE_BITS - 1)) begin
              state_q <= S_OUT;
            end
          end
          S_OUT: begin
            if (out_free) begin
              state_q <= S_IDLE;
            end
          end
          default: begin
            state_q <= S_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          addr_q <= {col_q, pos_q};
          wcol_q <= col_q;
          sample_q <= present_i ? sample_i : '0;
          pres_q <= present_i;
        end
      end
      S_EVICT: begin
        delta_q <= DELTA_W'(sample_q) - DELTA_W'(old_sample);
        oldp_q <= evict_q && ram_rdata[SAMPLE_BITS];
      end
      S_PREP: begin
        if (cnt_q[wcol_q] == '0) begin
          neg_q <= 1'b0;
          quo_q <= '0;
          res_valid_q <= 1'b0;
        end else begin
          neg_q <= sum_sel[SUM_W-1];
          rem_q <= mag[SUM_W-1:SAMPLE_BITS];
          quo_q <= mag[SAMPLE_BITS-1:0];
          div_q <= cnt_q[wcol_q];
          res_valid_q <= 1'b1;
        end
      end
      S_DIV: begin
        rem_q <= ge ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
        quo_q <= {quo_q[SAMPLE_BITS-2:0], ge};
      end
      S_OUT: begin
        if (out_free) begin
          mean_q <= mean_d;
          mean_valid_q <= res_valid_q;
          last_in_row_q <= last_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign mean_o = mean_q;
  assign mean_valid_o = mean_valid_q;
  assign last_in_row_o = last_in_row_q;

  `SWMM_ASSERT_NEXT(a_accept_reads_ring, in_accept && !clear_path, state_q == S_EVICT)
  `SWMM_ASSERT_IMPL(a_count_in_window, state_q == S_PREP, cnt_q[wcol_q] <= ws_eff)
  `SWMM_ASSERT_IMPL(a_div_operands, state_q == S_DIV, div_q != '0 && rem_q < div_q)
  `SWMM_ASSERT_IMPL(a_result_from_out, $rose(out_valid_q), $past(state_q) == S_OUT)

endmodule
